// File: rtl/core/sts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Token scanner package
// Types, character constants and classification functions shared by the
// scanner's modules.
// ----------------------------------------------------------------------------
package sts_pkg;

	typedef enum logic [12:0] {
		M_IDLE       = 13'b0000000000001,
		M_IDENT      = 13'b0000000000010,
		M_DOT        = 13'b0000000000100,
		M_SIGN       = 13'b0000000001000,
		M_DIGITS     = 13'b0000000010000,
		M_COMMENT    = 13'b0000000100000,
		M_HASH       = 13'b0000001000000,
		M_STRING     = 13'b0000010000000,
		M_ESCAPE     = 13'b0000100000000,
		M_CHAR_FIRST = 13'b0001000000000,
		M_CHAR_REST  = 13'b0010000000000,
		M_COMMA      = 13'b0100000000000,
		M_ERROR      = 13'b1000000000000
	} scan_mode_t;

	typedef enum logic [3:0] {
		K_LPAREN  = 4'd0,
		K_RPAREN  = 4'd1,
		K_DOT     = 4'd2,
		K_QUOTE   = 4'd3,
		K_QUASI   = 4'd4,
		K_UNQUOTE = 4'd5,
		K_SPLICE  = 4'd6,
		K_STRING  = 4'd7,
		K_IDENT   = 4'd8,
		K_NUMBER  = 4'd9,
		K_BOOL    = 4'd10,
		K_VEC     = 4'd11,
		K_CHAR    = 4'd12,
		K_END     = 4'd13,
		K_ERROR   = 4'd14
	} tok_kind_t;

	typedef enum logic [1:0] {
		E_NONE = 2'd0,
		E_CHAR = 2'd1,
		E_EOF  = 2'd2
	} err_kind_t;

	typedef struct packed {
		logic       text_valid;
		logic [7:0] text_byte;
		logic       token_end;
		tok_kind_t  token_kind;
		err_kind_t  error_kind;
		logic       last_result;
	} result_t;

	typedef struct packed {
		logic       has;
		result_t    res;
		scan_mode_t mode;
		logic       raise;
	} idle_t;

	typedef struct packed {
		result_t    res0;
		result_t    res1;
		logic [1:0] n;
		scan_mode_t next_mode;
		err_kind_t  next_err;
	} step_t;

	localparam logic [7:0] CH_NL     = 8'h0a;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_BQUOTE = 8'h60;

	function automatic logic is_space(logic [7:0] c);
		return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_sign(logic [7:0] c);
		return c == CH_PLUS || c == CH_MINUS;
	endfunction

	function automatic logic is_ident_start(logic [7:0] c);
		logic sym;
		sym = (c == "!") || (c == "$") || (c == "%") || (c == "&") || (c == "*") ||
			(c == "/") || (c == ":") || (c == "<") || (c == "=") || (c == ">") ||
			(c == "?") || (c == "~") || (c == "_") || (c == "^");
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || sym;
	endfunction

	function automatic logic is_follow(logic [7:0] c);
		return is_ident_start(c) || is_digit(c) || c == CH_DOT || is_sign(c);
	endfunction

	function automatic logic is_char_term(logic [7:0] c);
		return c == CH_LPAREN || c == CH_RPAREN || c == CH_HASH || c == CH_QUOTE ||
			c == CH_DQUOTE;
	endfunction

	function automatic logic [7:0] esc_map(logic [7:0] c);
		logic [7:0] r;
		unique case (c)
			"a":     r = 8'h07;
			"b":     r = 8'h08;
			"t":     r = 8'h09;
			"n":     r = 8'h0a;
			"v":     r = 8'h0b;
			"f":     r = 8'h0c;
			"r":     r = 8'h0d;
			default: r = c;
		endcase
		return r;
	endfunction

	function automatic result_t mk_text(logic [7:0] c);
		result_t r;
		r = '0;
		r.text_valid = 1'b1;
		r.text_byte  = c;
		r.token_kind = K_LPAREN;
		r.error_kind = E_NONE;
		return r;
	endfunction

	function automatic result_t mk_end(tok_kind_t k);
		result_t r;
		r = '0;
		r.token_end  = 1'b1;
		r.token_kind = k;
		r.error_kind = E_NONE;
		return r;
	endfunction

	function automatic result_t mk_full(logic [7:0] c, tok_kind_t k);
		result_t r;
		r = mk_text(c);
		r.token_end  = 1'b1;
		r.token_kind = k;
		return r;
	endfunction

	function automatic result_t mk_err(err_kind_t e);
		result_t r;
		r = mk_end(K_ERROR);
		r.error_kind = e;
		return r;
	endfunction

	function automatic idle_t idle_scan(logic [7:0] c, logic eof);
		idle_t r;
		r.has   = 1'b1;
		r.res   = mk_text(c);
		r.mode  = M_IDLE;
		r.raise = 1'b0;
		priority if (eof) begin
			r.res = mk_end(K_END);
		end else if (is_space(c)) begin
			r.has = 1'b0;
		end else if (c == CH_LPAREN) begin
			r.res = mk_full(c, K_LPAREN);
		end else if (c == CH_RPAREN) begin
			r.res = mk_full(c, K_RPAREN);
		end else if (c == CH_QUOTE) begin
			r.res = mk_full(c, K_QUOTE);
		end else if (c == CH_BQUOTE) begin
			r.res = mk_full(c, K_QUASI);
		end else if (is_ident_start(c)) begin
			r.mode = M_IDENT;
		end else if (is_sign(c)) begin
			r.mode = M_SIGN;
		end else if (is_digit(c)) begin
			r.mode = M_DIGITS;
		end else if (c == CH_DOT) begin
			r.mode = M_DOT;
		end else if (c == CH_SEMI) begin
			r.has  = 1'b0;
			r.mode = M_COMMENT;
		end else if (c == CH_COMMA) begin
			r.mode = M_COMMA;
		end else if (c == CH_HASH) begin
			r.mode = M_HASH;
		end else if (c == CH_DQUOTE) begin
			r.has  = 1'b0;
			r.mode = M_STRING;
		end else begin
			r.res   = mk_err(E_CHAR);
			r.mode  = M_ERROR;
			r.raise = 1'b1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/sts_char_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel carrying one source byte or an end-of-input mark per beat.
// ----------------------------------------------------------------------------
interface sts_char_if;

	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_input;

	modport source (output valid, output char_code, output end_of_input, input ready);
	modport sink (input valid, input char_code, input end_of_input, output ready);

endinterface
`default_nettype wire

// File: rtl/core/sts_token_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Token channel
// Valid/ready channel carrying one token text byte and/or token end per beat.
// ----------------------------------------------------------------------------
interface sts_token_if;

	logic       valid;
	logic       ready;
	logic       text_valid;
	logic [7:0] text_byte;
	logic       token_end;
	logic [3:0] token_kind;
	logic [1:0] error_kind;
	logic       last_result;

	modport source (
		output valid, output text_valid, output text_byte, output token_end,
		output token_kind, output error_kind, output last_result, input ready
	);
	modport sink (
		input valid, input text_valid, input text_byte, input token_end,
		input token_kind, input error_kind, input last_result, output ready
	);

endinterface
`default_nettype wire

// File: rtl/core/sts_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Scanner step
// Combinational next-mode and result logic for one character in the current mode.
// ----------------------------------------------------------------------------
module sts_step import sts_pkg::*; (
	input  scan_mode_t mode,
	input  err_kind_t  err,
	input  logic [7:0] char_code,
	input  logic       end_of_input,
	output step_t      step
);

	idle_t      idl;
	logic [7:0] c;
	logic       eof;
	logic [7:0] lc;

	assign c   = char_code;
	assign eof = end_of_input;
	assign lc  = (c >= "A" && c <= "Z") ? c + 8'd32 : c;

	always_comb begin
		idl = idle_scan(c, eof);
		step.res0      = mk_text(c);
		step.res1      = mk_text(c);
		step.n         = 2'd1;
		step.next_mode = mode;
		step.next_err  = err;
		unique case (mode)
			M_ERROR: begin
				step.res0 = mk_err(err);
			end
			M_IDENT: begin
				if (eof || !is_follow(c)) begin
					step.res0 = mk_end(K_IDENT);
				end
			end
			M_DOT: begin
				if (!eof && is_follow(c)) begin
					step.next_mode = M_IDENT;
				end else begin
					step.res0 = mk_end(K_DOT);
				end
			end
			M_SIGN: begin
				if (!eof && is_digit(c)) begin
					step.next_mode = M_DIGITS;
				end else if (!eof && is_follow(c)) begin
					step.next_mode = M_IDENT;
				end else begin
					step.res0 = mk_end(K_IDENT);
				end
			end
			M_DIGITS: begin
				if (!eof && is_digit(c)) begin
					step.next_mode = M_DIGITS;
				end else if (!eof && is_follow(c)) begin
					step.next_mode = M_IDENT;
				end else begin
					step.res0 = mk_end(K_NUMBER);
				end
			end
			M_COMMENT: begin
				if (eof) begin
					step.res0      = mk_end(K_END);
					step.next_mode = M_IDLE;
				end else begin
					step.n = 2'd0;
					if (c == CH_NL) begin
						step.next_mode = M_IDLE;
					end
				end
			end
			M_HASH: begin
				priority if (eof) begin
					step.res0 = mk_err(E_EOF);
				end else if (lc == "t" || lc == "f") begin
					step.res0      = mk_full(c, K_BOOL);
					step.next_mode = M_IDLE;
				end else if (c == CH_BSLASH) begin
					step.next_mode = M_CHAR_FIRST;
				end else if (c == CH_LPAREN) begin
					step.res0      = mk_full(c, K_VEC);
					step.next_mode = M_IDLE;
				end else if (is_sign(c)) begin
					step.next_mode = M_SIGN;
				end else if (is_digit(c)) begin
					step.next_mode = M_DIGITS;
				end else if (is_follow(c)) begin
					step.next_mode = M_IDENT;
				end else begin
					step.res0 = mk_end(K_NUMBER);
				end
			end
			M_STRING: begin
				priority if (eof) begin
					step.res0 = mk_err(E_EOF);
				end else if (c == CH_DQUOTE) begin
					step.res0      = mk_end(K_STRING);
					step.next_mode = M_IDLE;
				end else if (c == CH_BSLASH) begin
					step.n         = 2'd0;
					step.next_mode = M_ESCAPE;
				end
			end
			M_ESCAPE: begin
				if (eof) begin
					step.res0 = mk_err(E_EOF);
				end else begin
					step.res0      = mk_text(esc_map(c));
					step.next_mode = M_STRING;
				end
			end
			M_CHAR_FIRST: begin
				if (eof) begin
					step.res0 = mk_err(E_EOF);
				end else begin
					step.next_mode = M_CHAR_REST;
				end
			end
			M_CHAR_REST: begin
				if (eof || is_space(c) || is_char_term(c)) begin
					step.res0 = mk_end(K_CHAR);
				end
			end
			M_COMMA: begin
				if (!eof && c == CH_AT) begin
					step.res0      = mk_full(c, K_SPLICE);
					step.next_mode = M_IDLE;
				end else begin
					step.res0 = mk_end(K_UNQUOTE);
				end
			end
			default: begin
				step.res0      = idl.res;
				step.n         = {1'b0, idl.has};
				step.next_mode = idl.mode;
				if (idl.raise) begin
					step.next_err = E_CHAR;
				end
			end
		endcase

		if (mode != M_ERROR && step.res0.token_kind == K_ERROR && step.res0.token_end) begin
			step.next_mode = M_ERROR;
			step.next_err  = step.res0.error_kind;
		end

		// A token closed by its terminator: the terminator is scanned again from idle.
		if (mode != M_ERROR && mode != M_IDLE && step.res0.token_end &&
				!step.res0.text_valid && step.res0.token_kind != K_ERROR &&
				step.res0.token_kind != K_STRING && !(mode == M_COMMENT)) begin
			step.res1      = idl.res;
			step.n         = idl.has ? 2'd2 : 2'd1;
			step.next_mode = idl.mode;
			if (idl.raise) begin
				step.next_err = E_CHAR;
			end
		end

		if (step.n == 2'd1) begin
			step.res0.last_result = 1'b1;
		end
		if (step.n == 2'd2) begin
			step.res1.last_result = 1'b1;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/sts_out_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Token output buffer
// Two-entry result register that presents one beat at a time on the token channel.
// ----------------------------------------------------------------------------
module sts_out_buf import sts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  result_t     res0,
	input  result_t     res1,
	input  logic [1:0]  n,
	output logic        can_load,
	sts_token_if.source token_out
);

	result_t    head_q;
	result_t    tail_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop      = token_out.valid && token_out.ready;
	assign can_load = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= n;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			head_q <= res0;
			tail_q <= res1;
		end else if (pop) begin
			head_q <= tail_q;
		end
	end

	assign token_out.valid       = cnt_q != 2'd0;
	assign token_out.text_valid  = head_q.text_valid;
	assign token_out.text_byte   = head_q.text_byte;
	assign token_out.token_end   = head_q.token_end;
	assign token_out.token_kind  = head_q.token_kind;
	assign token_out.error_kind  = head_q.error_kind;
	assign token_out.last_result = head_q.last_result;

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("Output buffer count out of range.");
	assert property (@(posedge clk) disable iff (!arst_n) load |-> can_load)
		else $error("Results loaded while the buffer still holds unsent beats.");
	assert property (@(posedge clk) disable iff (!arst_n)
			(cnt_q == 2'd2) |-> !token_out.last_result)
		else $error("The first of two buffered beats is marked as the last.");

endmodule
`default_nettype wire

// File: rtl/core/sexpr_token_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// S-expression token scanner
// Splits a stream of source bytes into tokens, one character per beat, and
// emits each token's text bytes and its end with the token kind.
//
// Channel    Direction  Payload                                   Beat
// char_in    in         char_code, end_of_input                   one source byte
// token_out  out        text_valid, text_byte, token_end,         one result
//                       token_kind, error_kind, last_result
//
// A character is taken every cycle while it causes at most one result; one
// causing two results stalls the next one while both beats leave the two-entry
// output buffer. Data passes the input register, the step logic and the
// output buffer register. Reset clears the scan mode, the sticky error and
// all valid flags. A stall on token_out backs up through the buffer into char_in.
// ----------------------------------------------------------------------------
module sexpr_token_scanner import sts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sts_char_if.sink    char_in,
	sts_token_if.source token_out
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eof_s1;
	scan_mode_t mode_q;
	err_kind_t  err_q;
	step_t      step;
	logic       can_load;
	logic       step_fire;
	logic       load;

	assign step_fire     = valid_s1 && (step.n == 2'd0 || can_load);
	assign load          = step_fire && step.n != 2'd0;
	assign char_in.ready = !valid_s1 || step_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= M_IDLE;
			err_q    <= E_NONE;
		end else begin
			if (char_in.ready) begin
				valid_s1 <= char_in.valid;
			end
			if (step_fire) begin
				mode_q <= step.next_mode;
				err_q  <= step.next_err;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (char_in.ready && char_in.valid) begin
			char_s1 <= char_in.char_code;
			eof_s1  <= char_in.end_of_input;
		end
	end

	sts_step u_step (
		.mode         (mode_q),
		.err          (err_q),
		.char_code    (char_s1),
		.end_of_input (eof_s1),
		.step         (step)
	);

	sts_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.res0      (step.res0),
		.res1      (step.res1),
		.n         (step.n),
		.can_load  (can_load),
		.token_out (token_out)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
			(mode_q == M_ERROR) |=> (mode_q == M_ERROR))
		else $error("Scanner left the error mode before reset.");
	assert property (@(posedge clk) disable iff (!arst_n)
			(mode_q == M_ERROR) == (err_q != E_NONE))
		else $error("Saved error does not match the scan mode.");
	assert property (@(posedge clk) disable iff (!arst_n)
			(token_out.valid && token_out.token_kind == K_ERROR) |->
			(token_out.error_kind != E_NONE))
		else $error("Error beat without an error kind.");

endmodule
`default_nettype wire
